FILE: src/fssa_pkg.sv
// Shared types and constants for the free slot stack allocator.
// No dependencies; every other file in src uses it by scoped names.
`timescale 1ns / 1ps

package fssa_pkg;

   localparam int SLOT_COUNT = 256;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int DEPTH_W    = $clog2(SLOT_COUNT + 1);
   localparam int SLOT_IN_W  = 8;
   localparam int FREE_W     = 9;
   localparam int COUNT_W    = 32;
   localparam int CMP_W      = (DEPTH_W > SLOT_IN_W) ? DEPTH_W : SLOT_IN_W;

   typedef enum logic [1:0] {
      CMD_ALLOC_ANY  = 2'd0,
      CMD_ALLOC_SLOT = 2'd1,
      CMD_RELEASE    = 2'd2,
      CMD_NONE       = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_POP_WAIT,
      ST_PUSH,
      ST_EMIT
   } state_type;

endpackage

FILE: src/fssa_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on fssa_pkg for field widths.
`timescale 1ns / 1ps

interface fssa_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     command;
   logic [fssa_pkg::SLOT_IN_W-1:0] slot;

   modport source (output valid, command, slot, input ready);
   modport sink   (input valid, command, slot, output ready);
endinterface

interface fssa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           ok;
   logic [fssa_pkg::SLOT_IN_W-1:0] granted_slot;
   logic [fssa_pkg::FREE_W-1:0]    avail_count;
   logic [fssa_pkg::COUNT_W-1:0]   change_count;

   modport source (output valid, ok, granted_slot, avail_count, change_count, input ready);
   modport sink   (input valid, ok, granted_slot, avail_count, change_count, output ready);
endinterface

FILE: src/free_slot_stack_allocator_core.sv
// Free slot stack allocator: top level with the stack memory and its sequencer.
// Depends on fssa_pkg and the channel interfaces in fssa_if.sv.
`timescale 1ns / 1ps

// Usage
//   req_if carries one command word (command, slot); rsp_if returns exactly one
//   response word per command (ok, granted_slot, avail_count, change_count).
//   csr_wr_en/csr_wr_data write the duplicate-check enable; write it only while idle.
// Sequencing
//   One command at a time. Allocate-any steps through ST_POP_WAIT and plain
//   release through ST_PUSH before ST_EMIT; a refused release, an allocate on
//   an empty stack and the unused code go straight to ST_EMIT. Allocate-specific
//   and release with duplicate checking walk the stack memory from the bottom,
//   one read per cycle through its single read port, to a hit or the stack top.
//   The read-swap-write on allocate-specific reuses the same port: the top entry
//   is read after the search and written into the hit position.
//   The next command is accepted the cycle after the response loads.
// Reset
//   Synchronous reset starts a clearing pass that writes entry i with slot i,
//   one entry a cycle up to entry SLOT_COUNT - 1; req_if.ready stays low meanwhile.
// Stall
//   The response sits in an output register. A new command is accepted while it
//   waits; that command completes internally and holds in its last state until
//   the output register frees up.
module free_slot_stack_allocator_core (
   input  logic                clock,
   input  logic                reset,
   fssa_req_if.sink            req_if,
   fssa_rsp_if.source          rsp_if,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data
);

   localparam int SLOT_W    = fssa_pkg::SLOT_W;
   localparam int DEPTH_W   = fssa_pkg::DEPTH_W;
   localparam int SLOT_IN_W = fssa_pkg::SLOT_IN_W;
   localparam int COUNT_W   = fssa_pkg::COUNT_W;
   localparam int CMP_W     = fssa_pkg::CMP_W;

   // Stack memory: one write port, one registered read port.
   logic [SLOT_W-1:0] stack_mem [fssa_pkg::SLOT_COUNT];

   fssa_pkg::state_type state_ff, state_in;

   logic [SLOT_W-1:0]    clr_addr_ff, clr_addr_in;
   fssa_pkg::cmd_type    cmd_ff, cmd_in;
   logic [CMP_W-1:0]     slot_ff, slot_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 check_dup_ff;
   logic [DEPTH_W-1:0]   scan_addr_ff, scan_addr_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [SLOT_W-1:0]    rd_addr_ff;
   logic [SLOT_W-1:0]    rd_data_ff;
   logic                 found_ff, found_in;
   logic [SLOT_W-1:0]    pos_ff, pos_in;
   logic                 res_ok_ff, res_ok_in;
   logic [SLOT_IN_W-1:0] res_slot_ff, res_slot_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff;
   logic [SLOT_IN_W-1:0] rsp_slot_ff;
   logic [fssa_pkg::FREE_W-1:0] rsp_free_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 rsp_load;

   logic                 mem_we;
   logic [SLOT_W-1:0]    mem_waddr;
   logic [SLOT_W-1:0]    mem_wdata;
   logic [SLOT_W-1:0]    mem_raddr;

   // Decode of shared conditions.
   logic                 req_take;
   fssa_pkg::cmd_type    req_cmd;
   logic [CMP_W-1:0]     req_slot;
   logic                 req_in_range;
   logic                 stack_empty;
   logic                 stack_full;
   logic [DEPTH_W-1:0]   top_idx;
   logic                 clr_last;
   logic                 scan_hit;
   logic                 scan_done;
   logic                 scan_issue;
   logic                 out_free;

   always_comb begin
      req_take     = req_if.valid && req_if.ready;
      req_cmd      = fssa_pkg::cmd_type'(req_if.command);
      req_slot     = CMP_W'(req_if.slot);
      req_in_range = req_slot < CMP_W'(fssa_pkg::SLOT_COUNT);
      stack_empty  = depth_ff == '0;
      stack_full   = depth_ff >= DEPTH_W'(fssa_pkg::SLOT_COUNT);
      top_idx      = depth_ff - DEPTH_W'(1);
      clr_last     = clr_addr_ff == SLOT_W'(fssa_pkg::SLOT_COUNT - 1);
      // Compare the word read last cycle against the requested slot.
      scan_hit     = rd_pend_ff && (CMP_W'(rd_data_ff) == slot_ff);
      scan_done    = scan_hit || (!rd_pend_ff && (scan_addr_ff >= depth_ff));
      scan_issue   = !scan_done && (scan_addr_ff < depth_ff);
      out_free     = !rsp_valid_ff || rsp_if.ready;
   end

   assign req_if.ready = (state_ff == fssa_pkg::ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fssa_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = fssa_pkg::ST_IDLE;
            end
         end
         fssa_pkg::ST_IDLE: begin
            if (req_take) begin
               case (req_cmd)
                  fssa_pkg::CMD_ALLOC_ANY: begin
                     state_in = stack_empty ? fssa_pkg::ST_EMIT : fssa_pkg::ST_POP_WAIT;
                  end
                  fssa_pkg::CMD_ALLOC_SLOT: begin
                     if (stack_empty) begin
                        state_in = fssa_pkg::ST_EMIT;
                     end else if (req_in_range) begin
                        state_in = fssa_pkg::ST_SCAN;
                     end else begin
                        state_in = fssa_pkg::ST_POP_WAIT;
                     end
                  end
                  fssa_pkg::CMD_RELEASE: begin
                     if (!req_in_range || stack_full) begin
                        state_in = fssa_pkg::ST_EMIT;
                     end else if (check_dup_ff) begin
                        state_in = fssa_pkg::ST_SCAN;
                     end else begin
                        state_in = fssa_pkg::ST_PUSH;
                     end
                  end
                  default: begin
                     state_in = fssa_pkg::ST_EMIT;
                  end
               endcase
            end
         end
         fssa_pkg::ST_SCAN: begin
            if (scan_done) begin
               if (cmd_ff == fssa_pkg::CMD_RELEASE) begin
                  state_in = scan_hit ? fssa_pkg::ST_EMIT : fssa_pkg::ST_PUSH;
               end else begin
                  state_in = fssa_pkg::ST_POP_WAIT;
               end
            end
         end
         fssa_pkg::ST_POP_WAIT: state_in = fssa_pkg::ST_EMIT;
         fssa_pkg::ST_PUSH:     state_in = fssa_pkg::ST_EMIT;
         fssa_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = fssa_pkg::ST_IDLE;
            end
         end
         default: state_in = fssa_pkg::ST_CLEAR;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      clr_addr_in  = clr_addr_ff;
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      depth_in     = depth_ff;
      count_in     = count_ff;
      scan_addr_in = scan_addr_ff;
      rd_pend_in   = 1'b0;
      found_in     = found_ff;
      pos_in       = pos_ff;
      res_ok_in    = res_ok_ff;
      res_slot_in  = res_slot_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      mem_we       = 1'b0;
      mem_waddr    = clr_addr_ff;
      mem_wdata    = clr_addr_ff;
      // Read the top entry unless the search owns the port.
      mem_raddr    = top_idx[SLOT_W-1:0];

      case (state_ff)
         fssa_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + SLOT_W'(1);
         end
         fssa_pkg::ST_IDLE: begin
            if (req_take) begin
               cmd_in       = req_cmd;
               slot_in      = req_slot;
               scan_addr_in = '0;
               found_in     = 1'b0;
               res_ok_in    = 1'b0;
               res_slot_in  = '0;
            end
         end
         fssa_pkg::ST_SCAN: begin
            if (scan_hit) begin
               found_in = 1'b1;
               pos_in   = rd_addr_ff;
            end
            if (scan_issue) begin
               mem_raddr    = scan_addr_ff[SLOT_W-1:0];
               rd_pend_in   = 1'b1;
               scan_addr_in = scan_addr_ff + DEPTH_W'(1);
            end
         end
         fssa_pkg::ST_POP_WAIT: begin
            // On a hit, move the top entry into the hit position; in every case drop the top.
            if (found_ff) begin
               mem_we      = 1'b1;
               mem_waddr   = pos_ff;
               mem_wdata   = rd_data_ff;
               res_slot_in = SLOT_IN_W'(slot_ff);
            end else begin
               res_slot_in = SLOT_IN_W'(CMP_W'(rd_data_ff));
            end
            res_ok_in = 1'b1;
            depth_in  = depth_ff - DEPTH_W'(1);
            count_in  = count_ff + COUNT_W'(1);
         end
         fssa_pkg::ST_PUSH: begin
            mem_we    = 1'b1;
            mem_waddr = depth_ff[SLOT_W-1:0];
            mem_wdata = SLOT_W'(slot_ff);
            res_ok_in = 1'b1;
            depth_in  = depth_ff + DEPTH_W'(1);
            count_in  = count_ff + COUNT_W'(1);
         end
         fssa_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // Stack memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= stack_mem[mem_raddr];
      rd_addr_ff <= mem_raddr;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fssa_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         depth_ff     <= DEPTH_W'(fssa_pkg::SLOT_COUNT);
         count_ff     <= '0;
         check_dup_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            check_dup_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      slot_ff      <= slot_in;
      scan_addr_ff <= scan_addr_in;
      found_ff     <= found_in;
      pos_ff       <= pos_in;
      res_ok_ff    <= res_ok_in;
      res_slot_ff  <= res_slot_in;
      if (rsp_load) begin
         rsp_ok_ff    <= res_ok_ff;
         rsp_slot_ff  <= res_slot_ff;
         rsp_free_ff  <= fssa_pkg::FREE_W'(depth_ff);
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.ok           = rsp_ok_ff;
   assign rsp_if.granted_slot = rsp_slot_ff;
   assign rsp_if.avail_count  = rsp_free_ff;
   assign rsp_if.change_count = rsp_count_ff;

   // Checks.
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(fssa_pkg::SLOT_COUNT))
      else $error("stack depth above slot count");

   a_pop_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == fssa_pkg::ST_POP_WAIT |=>
         (depth_ff == $past(depth_ff) - DEPTH_W'(1)) &&
         (count_ff == $past(count_ff) + COUNT_W'(1)))
      else $error("pop did not step depth and change count");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == fssa_pkg::ST_CLEAR |-> !rsp_valid_ff)
      else $error("response during clearing pass");

   a_hit_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fssa_pkg::ST_SCAN) && scan_hit |-> DEPTH_W'(rd_addr_ff) < depth_ff)
      else $error("search hit above stack top");

endmodule
